// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dct2_pkg.sv =====
package dct2_pkg;

  // Transform direction codes.
  localparam logic DirForward = 1'b0;
  localparam logic DirInverse = 1'b1;

  // Block geometry: an 8 x 8 block, addressed row-major.
  localparam int BlockSize = 8;
  localparam int IdxW      = $clog2(BlockSize);
  localparam int Cells     = BlockSize * BlockSize;
  localparam int AddrW     = 2 * IdxW;

  localparam int CosW    = 16;
  localparam int AccW    = 64;
  localparam int FracW   = 28;

  // Quarter-wave cosine cos(m*pi/(2N)) in Q1.14 for m = 0..N, N = 8.
  // The values are the Q30 Taylor series of the quarter wave rounded to Q1.14.
  function automatic logic signed [CosW-1:0] quarter_cos(input int m);
    logic signed [CosW-1:0] v;
    case (m)
      0:       v = 16'sd16384;
      1:       v = 16'sd16069;
      2:       v = 16'sd15137;
      3:       v = 16'sd13623;
      4:       v = 16'sd11585;
      5:       v = 16'sd9102;
      6:       v = 16'sd6270;
      7:       v = 16'sd3196;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // Weighted cosine W(x,u) in Q1.14; the other quadrants follow by symmetry.
  function automatic logic signed [CosW-1:0] cos_weight(input int x, input int u);
    int kk, quad, r, m;
    logic signed [CosW-1:0] v;
    if (u == 0) begin
      return 16'sd11585;
    end
    kk = ((2 * x + 1) * u) & (4 * BlockSize - 1);
    quad = kk >> IdxW;
    r = kk & (BlockSize - 1);
    m = (quad == 1 || quad == 3) ? (BlockSize - r) : r;
    v = quarter_cos(m);
    if (quad == 1 || quad == 2) begin
      v = -v;
    end
    return v;
  endfunction

  // Command from the front to the back: one full block is ready.
  typedef struct packed {
    logic dir;
  } blk_cmd_t;

endpackage

// ===== rtl/core/dct2_front.sv =====
module dct2_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [15:0]                s_data_i,
  input  logic                       dir_i,
  input  logic                       busy_i,
  output logic [dct2_pkg::AddrW-1:0] wr_addr_o,
  output logic                       wr_en_o,
  output logic [15:0]                wr_data_o,
  output dct2_pkg::blk_cmd_t         cmd_o,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i
);
  import dct2_pkg::*;

  logic [AddrW-1:0] cnt_q, cnt_d;
  logic             full_q, full_d;
  logic             dir_q, dir_d;
  logic             acc;

  // The store is busy while a complete block waits for or is in the back end.
  assign s_ready_o   = !full_q && !busy_i;
  assign acc         = s_valid_i && s_ready_o;
  assign wr_en_o     = acc;
  assign wr_addr_o   = cnt_q;
  assign wr_data_o   = s_data_i;
  assign cmd_valid_o = full_q;
  assign cmd_o.dir   = dir_q;

  // Fill counter and block handoff.
  always_comb begin
    cnt_d  = cnt_q;
    full_d = full_q;
    dir_d  = dir_q;
    if (acc) begin
      if (cnt_q == AddrW'(Cells - 1)) begin
        cnt_d  = '0;
        full_d = 1'b1;
        dir_d  = dir_i;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (full_q && cmd_ready_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      full_q <= 1'b0;
      dir_q  <= DirForward;
    end else begin
      cnt_q  <= cnt_d;
      full_q <= full_d;
      dir_q  <= dir_d;
    end
  end
endmodule

// ===== rtl/core/dct2_back.sv =====
module dct2_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dct2_pkg::AddrW-1:0] wr_addr_i,
  input  logic                       wr_en_i,
  input  logic [15:0]                wr_data_i,
  input  dct2_pkg::blk_cmd_t         cmd_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [15:0]                m_data_o,
  output logic                       m_last_o,
  output logic                       busy_o
);
  import dct2_pkg::*;

  // Shift that divides the Q28 sum by N/2.
  localparam int Sh    = FracW + IdxW - 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  // Weight W(x,u) from the constant cosine table.
  function automatic logic signed [CosW-1:0] wtab(input logic [IdxW-1:0] x,
                                                  input logic [IdxW-1:0] u);
    return cos_weight(int'(x), int'(u));
  endfunction

  logic [15:0] mem [Cells];
  logic signed [15:0] rd_q, rd2_q;

  logic [1:0]       st_q, st_d;
  logic             dir_q, dir_d;
  logic [AddrW-1:0] oi_q, oi_d;   // output index p,q
  logic [AddrW-1:0] ii_q, ii_d;   // input index a,b
  logic             v1_q, v2_q, v3_q;
  logic signed [CosW-1:0] w1_q, w2_q;
  logic signed [31:0] pw_q;
  logic signed [47:0] pr_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [15:0]      res_q, res_d;
  logic             ov_q, ov_d, ol_q, ol_d;

  logic [IdxW-1:0] p, q, a, b;
  assign p = oi_q[AddrW-1:IdxW];
  assign q = oi_q[IdxW-1:0];
  assign a = ii_q[AddrW-1:IdxW];
  assign b = ii_q[IdxW-1:0];

  // Block store, written by the front and read once per cycle here.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[ii_q];
  end

  // Weight pair for the term being read, then the product pipeline.
  // The sample waits one stage so that it meets its own weight product.
  always_ff @(posedge clk_i) begin
    if (dir_q == DirForward) begin
      w1_q <= wtab(a, p);
      w2_q <= wtab(b, q);
    end else begin
      w1_q <= wtab(p, a);
      w2_q <= wtab(q, b);
    end
    rd2_q <= rd_q;
    pw_q  <= 32'(w1_q) * 32'(w2_q);
    pr_q  <= 48'(pw_q) * 48'(rd2_q);
  end

  logic issue;
  assign issue       = (st_q == StRun);
  assign cmd_ready_o = (st_q == StIdle);
  assign busy_o      = (st_q != StIdle);
  assign m_valid_o   = ov_q;
  assign m_data_o    = res_q;
  assign m_last_o    = ol_q;

  // Rounding, half away from zero; saturation is applied in the output state.
  logic [AccW-1:0] mag, qv;
  logic signed [AccW-1:0] sv;
  always_comb begin
    mag = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
    qv  = (mag + (AccW'(1) << (Sh - 1))) >> Sh;
    sv  = acc_q[AccW-1] ? -$signed(qv) : $signed(qv);
  end

  // Sequencer: one term per cycle in the run state, then a finish state that drains the pipeline and an output state.
  always_comb begin
    st_d = st_q; dir_d = dir_q; oi_d = oi_q; ii_d = ii_q; acc_d = acc_q;
    res_d = res_q; ov_d = ov_q; ol_d = ol_q;
    if (ov_q && m_ready_i) begin
      ov_d = 1'b0;
    end
    if (v3_q) begin
      acc_d = acc_q + AccW'(pr_q);
    end
    case (st_q)
      StIdle: begin
        if (cmd_valid_i) begin
          dir_d = cmd_i.dir; oi_d = '0; ii_d = '0; acc_d = '0; st_d = StRun;
        end
      end
      StRun: begin
        ii_d = ii_q + 1'b1;
        if (ii_q == AddrW'(Cells - 1)) begin
          st_d = StFin;
        end
      end
      StFin: begin
        if (!v1_q && !v2_q && !v3_q) begin
          st_d = StOut;
        end
      end
      StOut: begin
        if (!ov_q || m_ready_i) begin
          if (sv > 64'sd32767) begin
            res_d = 16'h7fff;
          end else if (sv < -64'sd32768) begin
            res_d = 16'h8000;
          end else begin
            res_d = sv[15:0];
          end
          ov_d  = 1'b1;
          ol_d  = (oi_q == AddrW'(Cells - 1));
          acc_d = '0;
          ii_d  = '0;
          oi_d  = oi_q + 1'b1;
          st_d  = (oi_q == AddrW'(Cells - 1)) ? StIdle : StRun;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; dir_q <= DirForward; oi_q <= '0; ii_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; acc_q <= '0;
      ov_q <= 1'b0; ol_q <= 1'b0; res_q <= '0;
    end else begin
      st_q <= st_d; dir_q <= dir_d; oi_q <= oi_d; ii_q <= ii_d;
      v1_q <= issue; v2_q <= v1_q; v3_q <= v2_q; acc_q <= acc_d;
      ov_q <= ov_d; ol_q <= ol_d; res_q <= res_d;
    end
  end
endmodule

// ===== rtl/core/dct_2d_block_core.sv =====
// Direct 2-D DCT-II / inverse over an N x N block (N = 8, fixed in the package).
// Input: s_axis_tdata carries one 16-bit signed sample per transfer, in
// row-major order. Output: m_axis_tdata carries one 16-bit signed result,
// m_axis_tlast marks the last result of a block.
// Configuration: cfg_valid_i/cfg_ready_o/cfg_data_i write the direction
// (0 forward, 1 inverse); it is sampled when a block's last sample arrives.
// The front fills the block store, one sample per cycle while the input is
// not stalled. When the block is complete the back end computes each result
// with one shared multiply path, one term per cycle, and finishes one result
// before it starts the next.
// The input is stalled while a full block waits for or is in the back end.
// A stalled output holds its result and pauses the sequencer.
// Reset drops any partial block and sets direction to forward.
module dct_2d_block_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // coefficient[15:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import dct2_pkg::*;

  `include "assert_macros.svh"

  logic             dir_q;
  logic [AddrW-1:0] wr_addr;
  logic             wr_en, cmd_valid, cmd_ready, busy;
  logic [15:0]      wr_data;
  blk_cmd_t         cmd;

  // Direction register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirForward;
    end else if (cfg_valid_i) begin
      dir_q <= cfg_data_i;
    end
  end

  dct2_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready), .s_data_i(s_axis_tdata),
    .dir_i(dir_q), .busy_i(busy), .wr_addr_o(wr_addr), .wr_en_o(wr_en),
    .wr_data_o(wr_data),
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  dct2_back u_back (
    .clk_i, .rst_ni,
    .wr_addr_i(wr_addr), .wr_en_i(wr_en), .wr_data_i(wr_data),
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_o(m_axis_tdata), .m_last_o(m_axis_tlast), .busy_o(busy)
  );

  // The store is never written while the back end holds or reads a block.
  `ASSERT_IMPL(a_no_write_busy, clk_i, rst_ni, cmd_valid || busy, !wr_en,
               "write into a block held by the back end")
  // A block is handed over only to an idle back end, which then turns busy.
  `ASSERT_NEXT(a_handoff, clk_i, rst_ni, cmd_valid && cmd_ready, busy,
               "back end did not start on a handed-over block")
  // A stalled output result holds.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
               "output changed while stalled")
endmodule
